### design/u8dec_pkg.sv
// ----------------------------------------------------------------------------
// u8dec_pkg
// Shared types and constants of the UTF-8 code point decoder.
// ----------------------------------------------------------------------------
package u8dec_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 21;
  localparam int unsigned UsedW = 3;
  localparam int unsigned CntW  = 3;

  localparam logic [CpW-1:0] ReplCp = CpW'(8'h3f);

  localparam logic [7:0] AsciiMask = 8'h80;
  localparam logic [7:0] Lead2Mask = 8'he0;
  localparam logic [7:0] Lead2Val  = 8'hc0;
  localparam logic [7:0] Lead3Mask = 8'hf0;
  localparam logic [7:0] Lead3Val  = 8'he0;
  localparam logic [7:0] Lead4Mask = 8'hf8;
  localparam logic [7:0] Lead4Val  = 8'hf0;
  localparam logic [7:0] ContMask  = 8'hc0;
  localparam logic [7:0] ContVal   = 8'h80;
  localparam logic [7:0] Pay2Mask  = 8'h1f;
  localparam logic [7:0] Pay3Mask  = 8'h0f;
  localparam logic [7:0] Pay4Mask  = 8'h07;
  localparam logic [7:0] ContPay   = 8'h3f;

  localparam logic [UsedW-1:0] Len2 = UsedW'(2);
  localparam logic [UsedW-1:0] Len3 = UsedW'(3);
  localparam logic [UsedW-1:0] Len4 = UsedW'(4);

  typedef struct packed {
    logic [UsedW-1:0] exp_len;
    logic [1:0]       held;
    logic [CpW-1:0]   accum;
  } seq_state_t;

  // results of one byte: nq replacement marks, then an optional tail result
  typedef struct packed {
    logic [CntW-1:0]  nq;
    logic             tail;
    logic [CpW-1:0]   cp;
    logic [UsedW-1:0] used;
  } burst_t;

endpackage

### design/u8dec_step.sv
// ----------------------------------------------------------------------------
// u8dec_step
// Decode of one byte against the open sequence: next state and result burst.
// ----------------------------------------------------------------------------
module u8dec_step (
  input  logic [u8dec_pkg::ByteW-1:0] byte_i,
  input  logic                        eot_i,
  input  u8dec_pkg::seq_state_t       state_i,
  output u8dec_pkg::seq_state_t       state_o,
  output u8dec_pkg::burst_t           burst_o
);

  logic [7:0]                  pay;
  logic [u8dec_pkg::CpW-1:0]   acc_sh;
  logic [u8dec_pkg::UsedW-1:0] held_inc;
  logic [u8dec_pkg::UsedW-1:0] fresh_len;
  logic                        is_cont;
  logic                        is_open;

  assign is_open  = (state_i.exp_len != '0);
  assign is_cont  = ((byte_i & u8dec_pkg::ContMask) == u8dec_pkg::ContVal);
  assign held_inc = u8dec_pkg::UsedW'(state_i.held) + u8dec_pkg::UsedW'(1);
  assign acc_sh   = {state_i.accum[u8dec_pkg::CpW-7:0],
                     byte_i[5:0] & u8dec_pkg::ContPay[5:0]};

  always_comb begin
    fresh_len = '0;
    pay       = '0;
    if ((byte_i & u8dec_pkg::Lead2Mask) == u8dec_pkg::Lead2Val) begin
      fresh_len = u8dec_pkg::Len2;
      pay       = byte_i & u8dec_pkg::Pay2Mask;
    end else if ((byte_i & u8dec_pkg::Lead3Mask) == u8dec_pkg::Lead3Val) begin
      fresh_len = u8dec_pkg::Len3;
      pay       = byte_i & u8dec_pkg::Pay3Mask;
    end else if ((byte_i & u8dec_pkg::Lead4Mask) == u8dec_pkg::Lead4Val) begin
      fresh_len = u8dec_pkg::Len4;
      pay       = byte_i & u8dec_pkg::Pay4Mask;
    end
  end

  always_comb begin
    state_o = '0;
    burst_o = '0;
    if (is_open && is_cont) begin
      if (held_inc >= state_i.exp_len) begin
        burst_o.tail = 1'b1;
        burst_o.cp   = acc_sh;
        burst_o.used = state_i.exp_len;
      end else if (eot_i) begin
        burst_o.nq = held_inc;
      end else begin
        state_o.exp_len = state_i.exp_len;
        state_o.held    = held_inc[1:0];
        state_o.accum   = acc_sh;
      end
    end else begin
      burst_o.nq = is_open ? u8dec_pkg::CntW'(state_i.held) : '0;
      priority if ((byte_i & u8dec_pkg::AsciiMask) == 8'h00) begin
        burst_o.tail = 1'b1;
        burst_o.cp   = u8dec_pkg::CpW'(byte_i);
        burst_o.used = u8dec_pkg::UsedW'(1);
      end else if (fresh_len == '0) begin
        burst_o.nq = burst_o.nq + u8dec_pkg::CntW'(1);
      end else if (eot_i) begin
        burst_o.nq = burst_o.nq + u8dec_pkg::CntW'(1);
      end else begin
        state_o.exp_len = fresh_len;
        state_o.held    = 2'd1;
        state_o.accum   = u8dec_pkg::CpW'(pay);
      end
    end
  end

endmodule

### design/utf8_codepoint_decoder_unit.sv
// ----------------------------------------------------------------------------
// utf8_codepoint_decoder_unit
// Streaming UTF-8 byte to code point decoder.
// ----------------------------------------------------------------------------
// One byte per cycle enters an input register unless the input stalls; it
// is then decoded against the open sequence and its results load into the
// result register. A byte that gives zero or one result stalls the input only
// on output back-pressure, so plain text flows at one byte per clock.
// A byte that gives n results (up to four, on broken or cut-off sequences)
// holds the result register and stalls the input until the last is taken.
module utf8_codepoint_decoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] text_byte
  input  logic        s_axis_tlast_i,   // end_of_text
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [20:0] code_point, [23:21] bytes_used
  output logic        m_axis_tuser_o,   // replaced
  output logic        m_axis_tlast_o    // run_last
);

  logic                        in_vld_q;
  logic [u8dec_pkg::ByteW-1:0] in_byte_q;
  logic                        in_eot_q;
  u8dec_pkg::seq_state_t       state_q, state_d;
  u8dec_pkg::burst_t           burst_q, burst_d;
  logic                        out_take;
  logic                        burst_done;
  logic                        advance;
  logic                        in_take;

  assign out_take   = m_axis_tvalid_o && m_axis_tready_i;
  assign burst_done = (burst_q.nq == '0 && !burst_q.tail) ||
                      (out_take && m_axis_tlast_o);
  assign advance    = in_vld_q && burst_done;
  assign s_axis_tready_o = !in_vld_q || advance;
  assign in_take    = s_axis_tvalid_i && s_axis_tready_o;

  u8dec_step u_step (
    .byte_i  (in_byte_q),
    .eot_i   (in_eot_q),
    .state_i (state_q),
    .state_o (state_d),
    .burst_o (burst_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= s_axis_tdata_i;
      in_eot_q  <= s_axis_tlast_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      burst_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
      burst_q <= burst_d;
    end else if (out_take) begin
      if (burst_q.nq != '0) begin
        burst_q.nq <= burst_q.nq - u8dec_pkg::CntW'(1);
      end else begin
        burst_q.tail <= 1'b0;
      end
    end
  end

  always_comb begin
    m_axis_tvalid_o = (burst_q.nq != '0) || burst_q.tail;
    if (burst_q.nq != '0) begin
      m_axis_tdata_o = {u8dec_pkg::UsedW'(1), u8dec_pkg::ReplCp};
      m_axis_tuser_o = 1'b1;
      m_axis_tlast_o = (burst_q.nq == u8dec_pkg::CntW'(1)) && !burst_q.tail;
    end else begin
      m_axis_tdata_o = {burst_q.used, burst_q.cp};
      m_axis_tuser_o = 1'b0;
      m_axis_tlast_o = 1'b1;
    end
  end

endmodule

### design/u8dec_checker.sv
// ----------------------------------------------------------------------------
// u8dec_checker
// Port-level checks of the UTF-8 decoder, bound to the top level.
// ----------------------------------------------------------------------------
module u8dec_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [23:0] m_axis_tdata_o,
  input logic        m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) &&
      $stable(m_axis_tlast_o))
    else $error("output transaction changed while stalled");

  a_repl_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |->
      m_axis_tdata_o == 24'h20003f)
    else $error("replacement result is not a single-byte question mark");

  a_used_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      m_axis_tdata_o[23:21] != 3'd0 && m_axis_tdata_o[23:21] <= 3'd4)
    else $error("bytes used out of range");

  a_ascii: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o && m_axis_tdata_o[23:21] == 3'd1 |->
      m_axis_tdata_o[20:7] == 14'd0)
    else $error("single-byte code point above 7 bits");

  a_not_last_repl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |-> m_axis_tuser_o)
    else $error("non-final result of a byte is not a replacement");

endmodule

bind utf8_codepoint_decoder_unit u8dec_checker u_u8dec_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the UTF-8 code point decoder against a cycle-free software decoder.
// Bytes go in over the input stream in random bursts, and decoded results are
// taken at random rates with long hold-offs. Each result is compared field by
// field with the oldest code point that the local decoder predicts.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned WatchLimit = 4000;

  typedef struct packed {
    logic [u8dec_pkg::ByteW-1:0] text_byte;
    logic                        end_of_text;
  } text_item_t;

  typedef struct packed {
    logic [u8dec_pkg::CpW-1:0]   code_point;
    logic                        replaced;
    logic [u8dec_pkg::UsedW-1:0] bytes_used;
    logic                        run_last;
  } code_point_t;

  logic                        clk_i   = 1'b0;
  logic                        rst_ni  = 1'b0;
  logic                        s_valid = 1'b0;
  logic                        s_ready;
  logic [u8dec_pkg::ByteW-1:0] s_data  = '0;
  logic                        s_last  = 1'b0;
  logic                        m_valid;
  logic                        m_ready = 1'b0;
  logic [23:0]                 m_data;
  logic                        m_user;
  logic                        m_last;

  text_item_t  text_in_q[$];
  code_point_t cp_batch[$];
  code_point_t cp_expect[$];

  // decoder state mirrored by the predictor
  logic [u8dec_pkg::UsedW-1:0] seq_len  = '0;
  logic [2:0]                  seq_held = '0;
  logic [u8dec_pkg::CpW-1:0]   seq_bits = '0;

  int unsigned err_count  = 0;
  int unsigned idle_count = 0;

  text_item_t  drv_item;
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  int unsigned rx_mode    = 0;
  int unsigned rx_timer   = 0;
  int unsigned rx_count   = 0;
  int unsigned hold_left  = 0;

  utf8_codepoint_decoder_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .m_axis_tlast_o  (m_last)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void add_code_point(logic [u8dec_pkg::CpW-1:0] cp, logic rep,
                                         logic [u8dec_pkg::UsedW-1:0] used);
    code_point_t r;
    r.code_point = cp;
    r.replaced   = rep;
    r.bytes_used = used;
    r.run_last   = 1'b0;
    cp_batch.insert(cp_batch.size(), r);
  endfunction

  function automatic void flush_held_bytes();
    repeat (seq_held) add_code_point(u8dec_pkg::ReplCp, 1'b1, u8dec_pkg::UsedW'(1));
    seq_len  = '0;
    seq_held = '0;
    seq_bits = '0;
  endfunction

  function automatic void start_sequence(logic [u8dec_pkg::ByteW-1:0] b, logic eot);
    logic opened;
    opened = 1'b1;
    if ((b & u8dec_pkg::AsciiMask) == '0) begin
      add_code_point(u8dec_pkg::CpW'(b), 1'b0, u8dec_pkg::UsedW'(1));
      opened = 1'b0;
    end else if ((b & u8dec_pkg::Lead2Mask) == u8dec_pkg::Lead2Val) begin
      seq_len  = u8dec_pkg::Len2;
      seq_bits = u8dec_pkg::CpW'(b & u8dec_pkg::Pay2Mask);
    end else if ((b & u8dec_pkg::Lead3Mask) == u8dec_pkg::Lead3Val) begin
      seq_len  = u8dec_pkg::Len3;
      seq_bits = u8dec_pkg::CpW'(b & u8dec_pkg::Pay3Mask);
    end else if ((b & u8dec_pkg::Lead4Mask) == u8dec_pkg::Lead4Val) begin
      seq_len  = u8dec_pkg::Len4;
      seq_bits = u8dec_pkg::CpW'(b & u8dec_pkg::Pay4Mask);
    end else begin
      add_code_point(u8dec_pkg::ReplCp, 1'b1, u8dec_pkg::UsedW'(1));
      opened = 1'b0;
    end
    if (opened) begin
      seq_held = 3'd1;
      if (eot) flush_held_bytes();
    end
  endfunction

  function automatic void decode_utf8_byte(logic [u8dec_pkg::ByteW-1:0] b, logic eot);
    logic [2:0] nheld;
    cp_batch.delete();
    if (seq_len != '0) begin
      if ((b & u8dec_pkg::ContMask) == u8dec_pkg::ContVal) begin
        seq_bits = (seq_bits << 6) | u8dec_pkg::CpW'(b & u8dec_pkg::ContPay);
        nheld    = seq_held + 3'd1;
        if (nheld >= seq_len) begin
          add_code_point(seq_bits, 1'b0, seq_len);
          seq_len  = '0;
          seq_held = '0;
          seq_bits = '0;
        end else begin
          seq_held = nheld;
          if (eot) flush_held_bytes();
        end
      end else begin
        flush_held_bytes();
        start_sequence(b, eot);
      end
    end else begin
      start_sequence(b, eot);
    end
    if (cp_batch.size() != 0) cp_batch[cp_batch.size()-1].run_last = 1'b1;
    foreach (cp_batch[i]) cp_expect.insert(cp_expect.size(), cp_batch[i]);
  endfunction

  task automatic push_byte(input logic [u8dec_pkg::ByteW-1:0] b, input logic eot);
    text_item_t it;
    it.text_byte   = b;
    it.end_of_text = eot;
    text_in_q.insert(text_in_q.size(), it);
  endtask

  task automatic push_random_text(input int unsigned n_items);
    int unsigned start;
    int unsigned kind;
    int unsigned len;
    int unsigned k;
    logic [u8dec_pkg::ByteW-1:0] b;
    start = text_in_q.size();
    while (text_in_q.size() - start < n_items) begin
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        len = $urandom_range(1, 4);
        case (len)
          1: b = u8dec_pkg::ByteW'($urandom_range(0, 127));
          2: b = u8dec_pkg::Lead2Val | u8dec_pkg::ByteW'($urandom_range(0, 31));
          3: b = u8dec_pkg::Lead3Val | u8dec_pkg::ByteW'($urandom_range(0, 15));
          default: b = u8dec_pkg::Lead4Val | u8dec_pkg::ByteW'($urandom_range(0, 7));
        endcase
        push_byte(b, $urandom_range(0, 19) == 0);
        for (k = 1; k < len; k++)
          push_byte(u8dec_pkg::ContVal | u8dec_pkg::ByteW'($urandom_range(0, 63)),
                    $urandom_range(0, 19) == 0);
      end else if (kind == 7) begin
        push_byte(u8dec_pkg::ByteW'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
      end else if (kind == 8) begin
        len = $urandom_range(2, 4);
        case (len)
          2: b = u8dec_pkg::Lead2Val | u8dec_pkg::ByteW'($urandom_range(0, 31));
          3: b = u8dec_pkg::Lead3Val | u8dec_pkg::ByteW'($urandom_range(0, 15));
          default: b = u8dec_pkg::Lead4Val | u8dec_pkg::ByteW'($urandom_range(0, 7));
        endcase
        push_byte(b, 1'b0);
        repeat ($urandom_range(0, len - 2))
          push_byte(u8dec_pkg::ContVal | u8dec_pkg::ByteW'($urandom_range(0, 63)), 1'b0);
        b = u8dec_pkg::ByteW'($urandom_range(0, 255));
        if ((b & u8dec_pkg::ContMask) == u8dec_pkg::ContVal) b = b | 8'h40;
        push_byte(b, $urandom_range(0, 4) == 0);
      end else begin
        if ($urandom_range(0, 1) == 0)
          b = u8dec_pkg::ContVal | u8dec_pkg::ByteW'($urandom_range(0, 63));
        else b = 8'hf8 | u8dec_pkg::ByteW'($urandom_range(0, 7));
        push_byte(b, $urandom_range(0, 9) == 0);
      end
    end
  endtask

  task automatic wait_drained();
    while (text_in_q.size() != 0 || s_valid) @(negedge clk_i);
    while (cp_expect.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    // plain ASCII, zero byte and the top of the range, then a two-byte form
    push_byte(8'h00, 1'b0);
    push_byte(8'h7f, 1'b1);
    push_byte(8'hc3, 1'b0);
    push_byte(8'ha9, 1'b0);
    // largest four-byte form
    push_byte(8'hf7, 1'b0);
    push_byte(8'hbf, 1'b0);
    push_byte(8'hbf, 1'b0);
    push_byte(8'hbf, 1'b0);
    // stray continuation and invalid lead
    push_byte(8'h80, 1'b0);
    push_byte(8'hf8, 1'b0);
    // sequence broken by ASCII
    push_byte(8'he2, 1'b0);
    push_byte(8'h82, 1'b0);
    push_byte(8'h41, 1'b0);
    // sequence broken by a lead that is itself cut off: four results
    push_byte(8'hf0, 1'b0);
    push_byte(8'h9f, 1'b0);
    push_byte(8'h98, 1'b0);
    push_byte(8'he2, 1'b1);
    // cut-off sequences, then a complete three-byte form and an invalid byte
    push_byte(8'hc3, 1'b1);
    push_byte(8'he2, 1'b0);
    push_byte(8'h82, 1'b1);
    push_byte(8'he2, 1'b0);
    push_byte(8'h82, 1'b0);
    push_byte(8'hac, 1'b0);
    push_byte(8'hff, 1'b0);
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_drained();
    push_random_text(150);
    wait_drained();
    push_random_text(150);
    wait_drained();
    repeat (20) @(negedge clk_i);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // sender: bursts of random length separated by random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
      s_data  <= '0;
      s_last  <= 1'b0;
    end else if (!s_valid || s_ready) begin
      if (gap_left != 0 || text_in_q.size() == 0) begin
        s_valid <= 1'b0;
        if (gap_left != 0) gap_left <= gap_left - 1;
      end else begin
        drv_item = text_in_q.pop_front();
        s_valid <= 1'b1;
        s_data  <= drv_item.text_byte;
        s_last  <= drv_item.end_of_text;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 30);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // receiver: stall pattern switching between modes, with long hold-offs
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      if (rx_timer == 0) begin
        rx_mode  <= $urandom_range(0, 2);
        rx_timer <= $urandom_range(16, 96);
      end else begin
        rx_timer <= rx_timer - 1;
      end
      if (m_valid && m_ready) rx_count <= rx_count + 1;
      if (hold_left != 0) begin
        m_ready   <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (m_valid && m_ready && (rx_count == 40 || rx_count == 200)) begin
        m_ready   <= 1'b0;
        hold_left <= 120;
      end else begin
        case (rx_mode)
          0: m_ready <= 1'b1;
          1: m_ready <= $urandom_range(0, 1);
          default: m_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // check results first, then predict from the byte taken at this edge
  always @(posedge clk_i) begin
    code_point_t exp_cp;
    if (rst_ni) begin
      if (m_valid && m_ready) begin
        if (cp_expect.size() == 0) begin
          err_count = err_count + 1;
          $error("unexpected result: code_point %0h", m_data[u8dec_pkg::CpW-1:0]);
        end else begin
          exp_cp = cp_expect.pop_front();
          if (m_data[u8dec_pkg::CpW-1:0] !== exp_cp.code_point) begin
            err_count = err_count + 1;
            $error("code_point: expected %0h, got %0h", exp_cp.code_point,
                   m_data[u8dec_pkg::CpW-1:0]);
          end
          if (m_user !== exp_cp.replaced) begin
            err_count = err_count + 1;
            $error("replaced: expected %0d, got %0d", exp_cp.replaced, m_user);
          end
          if (m_data[u8dec_pkg::CpW+u8dec_pkg::UsedW-1:u8dec_pkg::CpW] !==
              exp_cp.bytes_used) begin
            err_count = err_count + 1;
            $error("bytes_used: expected %0d, got %0d", exp_cp.bytes_used,
                   m_data[u8dec_pkg::CpW+u8dec_pkg::UsedW-1:u8dec_pkg::CpW]);
          end
          if (m_last !== exp_cp.run_last) begin
            err_count = err_count + 1;
            $error("run_last: expected %0d, got %0d", exp_cp.run_last, m_last);
          end
        end
      end
      if (s_valid && s_ready) decode_utf8_byte(s_data, s_last);
    end
  end

  always @(posedge clk_i) begin
    if (idle_count >= WatchLimit) begin
      $display("TEST FAILED");
      $finish;
    end else if (!rst_ni || (s_valid && s_ready) || (m_valid && m_ready)) begin
      idle_count <= 0;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

endmodule
